// ===== rtl/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// bole_pkg: shared types and constants for the bounded ordered list engine
// Request and status codes, plus the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int DATA_W       = 32;
  localparam int MODE_W       = 4;
  localparam int POS_W        = 5;
  localparam int LEN_W        = 5;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FIRST = 4'd0,
    MODE_INS_LAST  = 4'd1,
    MODE_INS_POS   = 4'd2,
    MODE_DEL_FIRST = 4'd3,
    MODE_DEL_LAST  = 4'd4,
    MODE_DEL_POS   = 4'd5,
    MODE_COUNT     = 4'd6,
    MODE_SEARCH    = 4'd7,
    MODE_DISPLAY   = 4'd8
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TOP,
    PTR_NEXT,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUT,
    WR_UP,
    WR_DOWN
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_RESP,
    OUT_ELEM
  } out_op_t;

  typedef struct packed {
    logic    req_load;
    ptr_op_t ptr_op;
    logic    rd_en;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    st_load;
    logic    found_clr;
    logic    found_acc;
    out_op_t out_op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t   mode;
    status_t chk_st;
    logic    at_end;
    logic    ptr_at_tgt;
    logic    ptr_at_top;
    logic    rd_at_top;
    logic    out_free;
  } dp_sts_t;

endpackage

// ===== rtl/bole_ctrl.sv =====
// ----------------------------------------------------------------------------
// bole_ctrl: request sequencer
// Decodes each request and steps the datapath through shifts, scans and
// display walks, one element per cycle (a display only while the output is free).
// ----------------------------------------------------------------------------
module bole_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bole_pkg::dp_sts_t sts,
  output bole_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_UP,
    S_DRAIN_UP,
    S_PUT,
    S_SHIFT_DN,
    S_DRAIN_DN,
    S_SCAN,
    S_SCAN_END,
    S_DISP_RD,
    S_DISP_OUT,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.req_load  = 1'b0;
    cmd.ptr_op    = bole_pkg::PTR_HOLD;
    cmd.rd_en     = 1'b0;
    cmd.wr_op     = bole_pkg::WR_NONE;
    cmd.cnt_op    = bole_pkg::CNT_HOLD;
    cmd.st_load   = 1'b0;
    cmd.found_clr = 1'b0;
    cmd.found_acc = 1'b0;
    cmd.out_op    = bole_pkg::OUT_NONE;
    case (state)
      S_IDLE: begin
        // No transaction is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.req_load = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.st_load   = 1'b1;
        cmd.found_clr = 1'b1;
        state_next    = S_RESP;
        case (sts.mode)
          bole_pkg::MODE_INS_FIRST, bole_pkg::MODE_INS_LAST,
          bole_pkg::MODE_INS_POS: begin
            if (sts.chk_st == bole_pkg::ST_OK) begin
              if (sts.at_end) begin
                state_next = S_PUT;
              end else begin
                cmd.ptr_op = bole_pkg::PTR_TOP;
                state_next = S_SHIFT_UP;
              end
            end
          end
          bole_pkg::MODE_DEL_FIRST, bole_pkg::MODE_DEL_LAST,
          bole_pkg::MODE_DEL_POS: begin
            if (sts.chk_st == bole_pkg::ST_OK) begin
              if (sts.at_end) begin
                // Dropping the tail needs no shift at all.
                cmd.cnt_op = bole_pkg::CNT_DEC;
              end else begin
                cmd.ptr_op = bole_pkg::PTR_NEXT;
                state_next = S_SHIFT_DN;
              end
            end
          end
          bole_pkg::MODE_SEARCH: begin
            if (sts.chk_st == bole_pkg::ST_OK) begin
              cmd.ptr_op = bole_pkg::PTR_ZERO;
              state_next = S_SCAN;
            end
          end
          bole_pkg::MODE_DISPLAY: begin
            if (sts.chk_st == bole_pkg::ST_OK) begin
              cmd.ptr_op = bole_pkg::PTR_ZERO;
              state_next = S_DISP_RD;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SHIFT_UP: begin
        cmd.rd_en = 1'b1;
        cmd.wr_op = bole_pkg::WR_UP;
        if (sts.ptr_at_tgt) begin
          state_next = S_DRAIN_UP;
        end else begin
          cmd.ptr_op = bole_pkg::PTR_DEC;
        end
      end
      S_DRAIN_UP: begin
        cmd.wr_op  = bole_pkg::WR_UP;
        state_next = S_PUT;
      end
      S_PUT: begin
        cmd.wr_op  = bole_pkg::WR_PUT;
        cmd.cnt_op = bole_pkg::CNT_INC;
        state_next = S_RESP;
      end
      S_SHIFT_DN: begin
        cmd.rd_en = 1'b1;
        cmd.wr_op = bole_pkg::WR_DOWN;
        if (sts.ptr_at_top) begin
          state_next = S_DRAIN_DN;
        end else begin
          cmd.ptr_op = bole_pkg::PTR_INC;
        end
      end
      S_DRAIN_DN: begin
        cmd.wr_op  = bole_pkg::WR_DOWN;
        cmd.cnt_op = bole_pkg::CNT_DEC;
        state_next = S_RESP;
      end
      S_SCAN: begin
        cmd.rd_en     = 1'b1;
        cmd.found_acc = 1'b1;
        if (sts.ptr_at_top) begin
          state_next = S_SCAN_END;
        end else begin
          cmd.ptr_op = bole_pkg::PTR_INC;
        end
      end
      S_SCAN_END: begin
        cmd.found_acc = 1'b1;
        state_next    = S_RESP;
      end
      S_DISP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.ptr_op = bole_pkg::PTR_INC;
        state_next = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        // The next read is issued as the current element leaves.
        if (sts.out_free) begin
          cmd.out_op = bole_pkg::OUT_ELEM;
          if (sts.rd_at_top) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = bole_pkg::PTR_INC;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_op = bole_pkg::OUT_RESP;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bole_dp.sv =====
// ----------------------------------------------------------------------------
// bole_dp: list datapath
// Element memory with one write and one registered read port, element
// count, walk pointer, request checks and the output register.
// ----------------------------------------------------------------------------
module bole_dp #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [bole_pkg::MODE_W-1:0]         mode,
  input  logic signed [bole_pkg::DATA_W-1:0]  value,
  input  logic [bole_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bole_pkg::STATUS_W-1:0]       status,
  output logic [bole_pkg::LEN_W-1:0]          length,
  output logic                                found,
  output logic signed [bole_pkg::DATA_W-1:0]  element,
  output logic                                last,
  input  bole_pkg::dp_cmd_t                   cmd,
  output bole_pkg::dp_sts_t                   sts
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam int XW = ((CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W) + 1;

  logic [bole_pkg::DATA_W-1:0]        mem [CAPACITY];
  logic [bole_pkg::MODE_W-1:0]        mode_q;
  logic signed [bole_pkg::DATA_W-1:0] value_q;
  logic [bole_pkg::POS_W-1:0]         pos_q;
  logic [CW-1:0]                      cnt;
  logic [PW-1:0]                      ptr;
  logic [PW-1:0]                      rd_addr_q;
  logic [bole_pkg::DATA_W-1:0]        rd_q;
  logic                               rd_vld;
  bole_pkg::status_t                  st_q;
  logic                               found_q;
  bole_pkg::status_t                  status_q;

  logic [PW-1:0]               tgt;
  logic [PW-1:0]               top;
  logic                        we;
  logic [PW-1:0]               wa;
  logic [bole_pkg::DATA_W-1:0] wd;
  bole_pkg::status_t           chk_st;
  logic                        at_end;
  logic                        out_free;

  assign top      = PW'(cnt - 1'b1);
  assign out_free = !out_valid || out_ready;

  // Request checks and the 0-based target slot.
  always_comb begin
    chk_st = bole_pkg::ST_OK;
    tgt    = '0;
    at_end = 1'b0;
    case (bole_pkg::mode_t'(mode_q))
      bole_pkg::MODE_INS_FIRST, bole_pkg::MODE_INS_LAST, bole_pkg::MODE_INS_POS: begin
        if (bole_pkg::mode_t'(mode_q) == bole_pkg::MODE_INS_LAST) begin
          tgt = PW'(cnt);
        end else if (bole_pkg::mode_t'(mode_q) == bole_pkg::MODE_INS_POS) begin
          tgt = PW'(pos_q - 1'b1);
        end
        at_end = (XW'(tgt) == XW'(cnt));
        if (cnt >= CW'(CAPACITY)) begin
          chk_st = bole_pkg::ST_FULL;
        end else if (bole_pkg::mode_t'(mode_q) == bole_pkg::MODE_INS_POS &&
                     (pos_q == '0 || XW'(pos_q) > XW'(cnt) + XW'(1))) begin
          chk_st = bole_pkg::ST_INVALID;
        end
      end
      bole_pkg::MODE_DEL_FIRST, bole_pkg::MODE_DEL_LAST, bole_pkg::MODE_DEL_POS: begin
        if (bole_pkg::mode_t'(mode_q) == bole_pkg::MODE_DEL_LAST) begin
          tgt = top;
        end else if (bole_pkg::mode_t'(mode_q) == bole_pkg::MODE_DEL_POS) begin
          tgt = PW'(pos_q - 1'b1);
        end
        at_end = (XW'(tgt) + XW'(1) == XW'(cnt));
        if (cnt == '0) begin
          chk_st = bole_pkg::ST_EMPTY;
        end else if (bole_pkg::mode_t'(mode_q) == bole_pkg::MODE_DEL_POS &&
                     (pos_q == '0 || XW'(pos_q) > XW'(cnt))) begin
          chk_st = bole_pkg::ST_INVALID;
        end
      end
      bole_pkg::MODE_COUNT: begin
        chk_st = bole_pkg::ST_OK;
      end
      bole_pkg::MODE_SEARCH, bole_pkg::MODE_DISPLAY: begin
        if (cnt == '0) begin
          chk_st = bole_pkg::ST_EMPTY;
        end
      end
      default: begin
        chk_st = bole_pkg::ST_INVALID;
      end
    endcase
  end

  // Shifts write the registered read data into the neighbor slot of the address it came from.
  always_comb begin
    we = 1'b0;
    wa = tgt;
    wd = value_q;
    case (cmd.wr_op)
      bole_pkg::WR_PUT: begin
        we = 1'b1;
      end
      bole_pkg::WR_UP: begin
        we = rd_vld;
        wa = rd_addr_q + 1'b1;
        wd = rd_q;
      end
      bole_pkg::WR_DOWN: begin
        we = rd_vld;
        wa = rd_addr_q - 1'b1;
        wd = rd_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q      <= mem[ptr];
      rd_addr_q <= ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      mode_q  <= mode;
      value_q <= value;
      pos_q   <= position;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.ptr_op)
      bole_pkg::PTR_TOP:  ptr <= top;
      bole_pkg::PTR_NEXT: ptr <= tgt + 1'b1;
      bole_pkg::PTR_ZERO: ptr <= '0;
      bole_pkg::PTR_INC:  ptr <= ptr + 1'b1;
      bole_pkg::PTR_DEC:  ptr <= ptr - 1'b1;
      default:            ptr <= ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd.cnt_op)
        bole_pkg::CNT_INC: cnt <= cnt + 1'b1;
        bole_pkg::CNT_DEC: cnt <= cnt - 1'b1;
        default:           cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st_load) begin
      st_q <= chk_st;
    end
    if (cmd.found_clr) begin
      found_q <= 1'b0;
    end else if (cmd.found_acc && rd_vld && rd_q == value_q) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_op != bole_pkg::OUT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.out_op)
      bole_pkg::OUT_RESP: begin
        status_q <= st_q;
        length   <= bole_pkg::LEN_W'(cnt);
        found    <= found_q;
        element  <= '0;
        last     <= 1'b1;
      end
      bole_pkg::OUT_ELEM: begin
        status_q <= bole_pkg::ST_OK;
        length   <= bole_pkg::LEN_W'(cnt);
        found    <= 1'b0;
        element  <= rd_q;
        last     <= (rd_addr_q == top);
      end
      default: begin
        status_q <= status_q;
      end
    endcase
  end

  assign status = status_q;

  assign sts.mode       = bole_pkg::mode_t'(mode_q);
  assign sts.chk_st     = chk_st;
  assign sts.at_end     = at_end;
  assign sts.ptr_at_tgt = (ptr == tgt);
  assign sts.ptr_at_top = (ptr == top);
  assign sts.rd_at_top  = (rd_addr_q == top);
  assign sts.out_free   = out_free;

endmodule

// ===== rtl/bounded_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: bounded ordered list of signed 32-bit values
// Insert, delete, count, search and display on a list of up to CAPACITY
// elements kept in order in an element memory with one read and one write port.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------
//   request   in_valid / in_ready    mode, value, position
//   result    out_valid / out_ready  status, length, found, element, last
//
// One request is handled at a time; the next is taken once the previous
// one has loaded its last result into the output register.
// Count, errors and a tail delete or insert need no walk; a shift, search
// or display walks the list element by element over the single read port.
// Output stalls hold the sequencer; a display emits one element per cycle while the output is free.
// Reset clears the element count and the valid flags and idles the sequencer; the memory needs no clearing pass.
//
module bounded_ordered_list_engine #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bole_pkg::MODE_W-1:0]         mode,
  input  logic signed [bole_pkg::DATA_W-1:0]  value,
  input  logic [bole_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bole_pkg::STATUS_W-1:0]       status,
  output logic [bole_pkg::LEN_W-1:0]          length,
  output logic                                found,
  output logic signed [bole_pkg::DATA_W-1:0]  element,
  output logic                                last
);

  bole_pkg::dp_cmd_t dp_cmd;
  bole_pkg::dp_sts_t dp_sts;

  bole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  bole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .length    (length),
    .found     (found),
    .element   (element),
    .last      (last),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  // Once a transaction is taken, the engine is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("engine ready right after accepting a request");

  // No element may be written while the engine waits for a request.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> dp_cmd.wr_op == bole_pkg::WR_NONE)
    else $error("element memory written while idle");

  // Only display elements come out without last, and they always report ok.
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == bole_pkg::ST_OK && !found)
    else $error("non-final result with bad status or found set");

endmodule
